// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console character writer: cell
// layout, special character codes, controller states, command and status.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // cell and field layout
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int POS_OUT_W = 11;

  // screen size defaults
  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  // character and attribute codes
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

  // input command codes
  localparam logic CMD_PUT   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,   // blanking pass after reset
    ST_IDLE,   // waiting for an item
    ST_CLEAR,  // blanking pass for a clear command
    ST_COPY,   // scroll: move rows up one cell per cycle
    ST_DRAIN,  // scroll: last copy write lands
    ST_BLANK,  // scroll: blank the bottom row
    ST_WRITE,  // write the character cell and post the result
    ST_DONE    // post the result
  } tcw_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;    // latch character and scroll flag
    logic cur_home;     // cursor to column 0, row 0
    logic col_zero;     // cursor column to 0
    logic row_inc;      // cursor row plus one
    logic scroll_set;   // mark the item as scrolled
    logic idx_clear;    // sweep index to 0
    logic idx_inc;      // sweep index plus one
    logic copy_rd;      // read the cell one row below the index
    logic blank_wr;     // write a blank cell at the index
    logic blank_reset;  // blank with the reset attribute
    logic char_wr;      // write the character at the cursor, advance column
    logic out_load;     // load the result register
  } tcw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_clear;       // offered item is a clear command
    logic in_newline;     // offered item is a newline
    logic col_at_end;     // column is past the end of the row
    logic row_last;       // cursor on the last row
    logic idx_copy_last;  // last copy source step
    logic idx_last;       // index at the last cell
    logic out_free;       // result register can take a result
  } tcw_stat_t;

endpackage

// ===== design/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller for the console writer: decodes each item, sequences clearing,
// scrolling and the cell write, and hands the result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcw_stat_t stat,
  output tcw_cmd_t  cmd
);

  tcw_state_t state, state_next;
  logic       pend_write, pend_write_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      pend_write <= 1'b0;
    end else begin
      state      <= state_next;
      pend_write <= pend_write_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    pend_write_next = pend_write;
    cmd             = '0;
    in_ready        = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.blank_wr    = 1'b1;
        cmd.blank_reset = 1'b1;
        cmd.idx_inc     = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item   = 1'b1;
          cmd.idx_clear   = 1'b1;
          pend_write_next = 1'b0;
          if (stat.in_clear) begin
            cmd.cur_home = 1'b1;
            state_next   = ST_CLEAR;
          end else if (stat.in_newline) begin
            cmd.col_zero = 1'b1;
            if (stat.row_last) begin
              cmd.scroll_set = 1'b1;
              state_next     = ST_COPY;
            end else begin
              cmd.row_inc = 1'b1;
              state_next  = ST_DONE;
            end
          end else if (stat.col_at_end) begin
            cmd.col_zero = 1'b1;
            if (stat.row_last) begin
              cmd.scroll_set  = 1'b1;
              pend_write_next = 1'b1;
              state_next      = ST_COPY;
            end else begin
              cmd.row_inc = 1'b1;
              state_next  = ST_WRITE;
            end
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_CLEAR: begin
        cmd.blank_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        cmd.copy_rd = 1'b1;
        cmd.idx_inc = 1'b1;
        if (stat.idx_copy_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        cmd.blank_wr = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.idx_last) begin
          state_next = pend_write ? ST_WRITE : ST_DONE;
        end
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.char_wr  = 1'b1;
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tcw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen cell memory, cursor registers, sweep index and result register of
// the console writer, driven by commands from the controller.
// ----------------------------------------------------------------------------
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 attr_wr_en,
  input  logic [ATTR_W-1:0]    attr_wr_data,
  input  logic                 in_cmd,
  input  logic [CHAR_W-1:0]    in_char,
  input  tcw_cmd_t             cmd,
  output tcw_stat_t            stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_OUT_W-1:0] out_pos,
  output logic                 out_scrolled
);

  localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(SCREEN_COLUMNS + 1);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int FULL_W = $clog2(CELLS + 1);
  localparam int PW     = (FULL_W > POS_OUT_W) ? FULL_W : POS_OUT_W;

  logic [ATTR_W-1:0] attr;
  logic [CHAR_W-1:0] char_held;
  logic              scroll_flag;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] idx;
  logic              copy_pend;
  logic [ADDR_W-1:0] copy_addr;
  logic [CELL_W-1:0] rdata;
  logic [CELL_W-1:0] mem [CELLS];

  logic [PW-1:0]     base;
  logic [PW-1:0]     cur_lin;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] blank_cell;
  logic [CELL_W-1:0] char_cell;

  // attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= RESET_ATTR;
    end else if (attr_wr_en) begin
      attr <= attr_wr_data;
    end
  end

  // cursor registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else begin
      if (cmd.cur_home || cmd.col_zero) begin
        col <= '0;
      end else if (cmd.char_wr) begin
        col <= col + COL_W'(1);
      end
      if (cmd.cur_home) begin
        row <= '0;
      end else if (cmd.row_inc) begin
        row <= row + ROW_W'(1);
      end
    end
  end

  // held character and scroll flag of the item in work
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      char_held   <= in_char;
      scroll_flag <= cmd.scroll_set;
    end
  end

  // sweep index and copy write pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      copy_pend <= 1'b0;
    end else begin
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + ADDR_W'(1);
      end
      copy_pend <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      copy_addr <= idx;
    end
  end

  // cursor address
  assign base       = PW'(row) * PW'(SCREEN_COLUMNS);
  assign cur_lin    = base + PW'(col);
  assign waddr      = cur_lin[ADDR_W-1:0];
  assign raddr      = idx + ADDR_W'(SCREEN_COLUMNS);
  assign blank_cell = {(cmd.blank_reset ? RESET_ATTR : attr), BLANK_CHAR};
  assign char_cell  = {attr, char_held};

  // screen memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (copy_pend) begin
      mem[copy_addr] <= rdata;
    end else if (cmd.blank_wr) begin
      mem[idx] <= blank_cell;
    end else if (cmd.char_wr) begin
      mem[waddr] <= char_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy_rd) begin
      rdata <= mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_scrolled <= scroll_flag;
      out_pos      <= POS_OUT_W'(cur_lin + PW'(cmd.char_wr));
    end
  end

  // status to controller
  assign stat.in_clear      = (in_cmd == CMD_CLEAR);
  assign stat.in_newline    = (in_char == NEWLINE_CHAR);
  assign stat.col_at_end    = (col == COL_W'(SCREEN_COLUMNS));
  assign stat.row_last      = (row == ROW_W'(SCREEN_ROWS - 1));
  assign stat.idx_copy_last = (idx == ADDR_W'(CELLS - SCREEN_COLUMNS - 1));
  assign stat.idx_last      = (idx == ADDR_W'(CELLS - 1));
  assign stat.out_free      = !out_valid || out_ready;

endmodule

// ===== design/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text-mode console engine: character writes, newline, wrap, scroll, clear.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tdata carries the character byte, tuser the
// command (0 put, 1 clear screen). Each item yields one result on m_axis:
// tdata carries the linear cursor position, tuser the scrolled flag.
// The attribute byte for written cells and for cells blanked by clear or scroll
// is set through attr_wr_en / attr_wr_data, one write per cycle, no read-back.
// An ordinary character or a newline without scroll is accepted, then the cell
// write (for a character) and the result load follow once the output register is free.
// A scroll walks the screen memory: it copies the rows up one row, drains
// the last copy write, blanks the bottom row, then does the cell write or
// posts the result. A clear blanks every cell, then posts the result.
// After reset the block blanks the whole screen, one cell per cycle
// (SCREEN_COLUMNS * SCREEN_ROWS cells, 2000 by default), and accepts no item
// until that pass ends; attribute writes are taken meanwhile.
// The result waits in an output register; a new item is taken while it
// waits, and the next item stalls only when its own result is ready and the
// register is still full.
// ----------------------------------------------------------------------------
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  logic              clk,
  input  logic              rst,
  // attribute register write
  input  logic              attr_wr_en,
  input  logic [ATTR_W-1:0] attr_wr_data,
  // input items
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
  input  logic              s_axis_tuser,   // [0] cmd
  // result items
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,   // [10:0] cursor_position, [15:11] zero
  output logic              m_axis_tuser    // [0] scrolled
);

  tcw_cmd_t             cmd;
  tcw_stat_t            stat;
  logic [POS_OUT_W-1:0] out_pos;

  // controller
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  tcw_datapath #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .attr_wr_en   (attr_wr_en),
    .attr_wr_data (attr_wr_data),
    .in_cmd       (s_axis_tuser),
    .in_char      (s_axis_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_pos      (out_pos),
    .out_scrolled (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, out_pos};

endmodule
